// ===== rtl/sxrx_pkg.sv =====
// shared types, constants and helpers for the sysex patch receiver
// no dependencies
`default_nettype none

package sxrx_pkg;

    localparam int unsigned PATCH_BYTES_DEF = 1536;
    localparam int unsigned HEADER_LEN = 5;

    localparam logic [7:0] DEFAULT_PORT = 8'h00;

    localparam logic [7:0] BYTE_EOX = 8'hf7;
    localparam logic [7:0] HDR_B0 = 8'hf0;
    localparam logic [7:0] HDR_B1 = 8'h00;
    localparam logic [7:0] HDR_B2 = 8'h00;
    localparam logic [7:0] HDR_B3 = 8'h7e;
    localparam logic [7:0] HDR_B4 = 8'h44;

    localparam logic [7:0] CMD_FULL_READ   = 8'h01;
    localparam logic [7:0] CMD_PATCH_WRITE = 8'h02;
    localparam logic [7:0] CMD_BLOCK_READ  = 8'h03;
    localparam logic [7:0] CMD_BLOCK_WRITE = 8'h04;
    localparam logic [7:0] CMD_PING        = 8'h0f;

    localparam logic [15:0] BLOCK_BYTES    = 16'd256;
    localparam logic [15:0] BLOCK_WRITE_CNT = 16'd257;
    localparam logic [15:0] COUNT_MAX      = 16'hffff;

    localparam logic [2:0] KIND_WRITE      = 3'd0;
    localparam logic [2:0] KIND_ACK        = 3'd1;
    localparam logic [2:0] KIND_DISACK     = 3'd2;
    localparam logic [2:0] KIND_FULL_DUMP  = 3'd3;
    localparam logic [2:0] KIND_BLOCK_DUMP = 3'd4;

    localparam logic [1:0] REASON_FEWER    = 2'd0;
    localparam logic [1:0] REASON_MORE     = 2'd1;
    localparam logic [1:0] REASON_CHECKSUM = 2'd2;
    localparam logic [1:0] REASON_INVALID  = 2'd3;

    localparam logic REQ_BYTE    = 1'b0;
    localparam logic REQ_TIMEOUT = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] port;
        logic [7:0] midi_byte;
    } req_t;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [14:0] write_addr;
        logic [6:0]  write_data;
        logic [1:0]  disack_reason;
        logic [6:0]  dump_block;
        logic [7:0]  reply_port;
        logic        commit_patch;
    } rsp_t;

    function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = HDR_B0;
            3'd1:    b = HDR_B1;
            3'd2:    b = HDR_B2;
            3'd3:    b = HDR_B3;
            3'd4:    b = HDR_B4;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic rsp_t make_rsp(
        input logic [2:0]  kind,
        input logic [14:0] addr,
        input logic [6:0]  data,
        input logic [1:0]  reason,
        input logic [6:0]  blk,
        input logic [7:0]  rport,
        input logic        commit
    );
        rsp_t r;
        r.result_kind   = kind;
        r.write_addr    = addr;
        r.write_data    = data;
        r.disack_reason = reason;
        r.dump_block    = blk;
        r.reply_port    = rport;
        r.commit_patch  = commit;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sxrx_req_if.sv =====
// valid/ready channel carrying received midi bytes and timeout events
// no dependencies
`default_nettype none

interface sxrx_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] port;
    logic [7:0] midi_byte;

    modport source (output valid, output req_type, output port, output midi_byte,
                    input ready);
    modport sink (input valid, input req_type, input port, input midi_byte,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/sxrx_rsp_if.sv =====
// valid/ready channel carrying patch writes, acks, disacks and dump requests
// no dependencies
`default_nettype none

interface sxrx_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  result_kind;
    logic [14:0] write_addr;
    logic [6:0]  write_data;
    logic [1:0]  disack_reason;
    logic [6:0]  dump_block;
    logic [7:0]  reply_port;
    logic        commit_patch;

    modport source (output valid, output result_kind, output write_addr,
                    output write_data, output disack_reason, output dump_block,
                    output reply_port, output commit_patch, input ready);
    modport sink (input valid, input result_kind, input write_addr,
                  input write_data, input disack_reason, input dump_block,
                  input reply_port, input commit_patch, output ready);
endinterface

`default_nettype wire

// ===== rtl/midi_sysex_patch_receiver_core.sv =====
// sysex patch receiver top level: input register, parser, result register
// flow: an accepted transaction waits in the input register, its result in the result register
// throughput: one transaction per cycle while the result side keeps taking
// reset: clears the parser state, locked port to the default, both stages empty
// depends on sxrx_pkg, sxrx_req_if, sxrx_rsp_if, sxrx_parser
`default_nettype none

module midi_sysex_patch_receiver_core
    import sxrx_pkg::*;
#(
    parameter int unsigned PATCH_BYTES = PATCH_BYTES_DEF
)(
    input  wire logic clk,
    input  wire logic rst_n,
    sxrx_req_if.sink  req,
    sxrx_rsp_if.source rsp
);

    logic s1_valid_reg, s1_valid_next;
    req_t s1_item_reg;
    logic out_valid_reg, out_valid_next;
    rsp_t out_reg;

    logic advance;
    logic out_free;
    logic res_valid;
    rsp_t res;
    req_t in_item;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign advance   = s1_valid_reg && out_free;
    assign req.ready = !s1_valid_reg || advance;

    assign in_item.req_type  = req.req_type;
    assign in_item.port      = req.port;
    assign in_item.midi_byte = req.midi_byte;

    sxrx_parser #(
        .PATCH_BYTES(PATCH_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (s1_item_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        s1_valid_next  = req.ready ? req.valid : s1_valid_reg;
        out_valid_next = out_free ? (advance && res_valid) : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
            s1_item_reg <= in_item;
        if (advance && res_valid)
            out_reg <= res;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.result_kind   = out_reg.result_kind;
    assign rsp.write_addr    = out_reg.write_addr;
    assign rsp.write_data    = out_reg.write_data;
    assign rsp.disack_reason = out_reg.disack_reason;
    assign rsp.dump_block    = out_reg.dump_block;
    assign rsp.reply_port    = out_reg.reply_port;
    assign rsp.commit_patch  = out_reg.commit_patch;

    // the parser only reports while a held transaction is consumed
    a_res_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> advance)
        else $error("parser result without a consumed transaction");

    // an accepted transaction lands in the input stage
    a_input_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> s1_valid_reg)
        else $error("accepted transaction lost at input stage");

    // a result that waits is not overwritten
    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("pending result changed while stalled");

    // patch writes carry no reply port and no commit
    a_write_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.result_kind == KIND_WRITE)
            |-> (out_reg.reply_port == 8'd0 && !out_reg.commit_patch))
        else $error("patch write with reply fields set");

endmodule

`default_nettype wire

// ===== rtl/sxrx_parser.sv =====
// sysex header match, port lock, command decode and checksum state
// depends on sxrx_pkg
`default_nettype none

module sxrx_parser
    import sxrx_pkg::*;
#(
    parameter int unsigned PATCH_BYTES = PATCH_BYTES_DEF
)(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic step,
    input  wire req_t item,
    output logic      res_valid,
    output rsp_t      res
);

    localparam logic [15:0] PATCH_CNT  = 16'(PATCH_BYTES);
    localparam logic [15:0] PATCH_DONE = 16'(PATCH_BYTES + 1);
    localparam logic [7:0]  LAST_BLOCK = 8'((PATCH_BYTES - 1) / 256);

    logic [2:0]  header_count_reg, header_count_next;
    logic        in_message_reg, in_message_next;
    logic        command_seen_reg, command_seen_next;
    logic        block_seen_reg, block_seen_next;
    logic [7:0]  command_code_reg, command_code_next;
    logic [7:0]  locked_port_reg, locked_port_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [7:0]  received_sum_reg, received_sum_next;
    logic [15:0] byte_count_reg, byte_count_next;
    logic [7:0]  block_number_reg, block_number_next;

    logic [7:0]  neg_sum;
    logic        sum_ok;
    logic [15:0] count_inc;
    logic        do_finish;
    logic [7:0]  b;

    assign neg_sum   = 8'd0 - running_sum_reg;
    assign sum_ok    = received_sum_reg == {1'b0, neg_sum[6:0]};
    assign count_inc = (byte_count_reg == COUNT_MAX) ? byte_count_reg
                                                     : byte_count_reg + 16'd1;
    assign b = item.midi_byte;

    always_comb
    begin
        header_count_next = header_count_reg;
        in_message_next   = in_message_reg;
        command_seen_next = command_seen_reg;
        block_seen_next   = block_seen_reg;
        command_code_next = command_code_reg;
        locked_port_next  = locked_port_reg;
        running_sum_next  = running_sum_reg;
        received_sum_next = received_sum_reg;
        byte_count_next   = byte_count_reg;
        block_number_next = block_number_reg;
        do_finish = 1'b0;
        res_valid = 1'b0;
        res       = '0;

        if (step)
        begin
            if (item.req_type == REQ_TIMEOUT)
            begin
                if (in_message_reg && item.port == locked_port_reg)
                    do_finish = 1'b1;
            end
            else if (!(in_message_reg && item.port != locked_port_reg))
            begin
                locked_port_next = item.port;
                if (!in_message_reg)
                begin
                    // header match, mismatch restarts without recheck
                    if (header_count_reg >= 3'(HEADER_LEN)
                        || b != hdr_byte(header_count_reg))
                    begin
                        do_finish = 1'b1;
                    end
                    else
                    begin
                        header_count_next = header_count_reg + 3'd1;
                        if (header_count_reg == 3'(HEADER_LEN - 1))
                            in_message_next = 1'b1;
                    end
                end
                else if (b[7])
                begin
                    if (b == BYTE_EOX && command_seen_reg)
                    begin
                        res_valid = 1'b1;
                        case (command_code_reg)
                            CMD_FULL_READ:
                                res = make_rsp(KIND_FULL_DUMP, '0, '0, '0, '0,
                                               locked_port_reg, 1'b0);
                            CMD_PATCH_WRITE:
                                if (byte_count_reg < PATCH_DONE)
                                    res = make_rsp(KIND_DISACK, '0, '0, REASON_FEWER, '0,
                                                   locked_port_reg, 1'b0);
                                else if (byte_count_reg > PATCH_DONE)
                                    res = make_rsp(KIND_DISACK, '0, '0, REASON_MORE, '0,
                                                   locked_port_reg, 1'b0);
                                else if (!sum_ok)
                                    res = make_rsp(KIND_DISACK, '0, '0, REASON_CHECKSUM,
                                                   '0, locked_port_reg, 1'b0);
                                else
                                    res = make_rsp(KIND_ACK, '0, '0, '0, '0,
                                                   locked_port_reg, 1'b1);
                            CMD_BLOCK_READ:
                                if (!block_seen_reg)
                                    res = make_rsp(KIND_DISACK, '0, '0, REASON_FEWER, '0,
                                                   locked_port_reg, 1'b0);
                                else
                                    res = make_rsp(KIND_BLOCK_DUMP, '0, '0, '0,
                                                   block_number_reg[6:0],
                                                   locked_port_reg, 1'b0);
                            CMD_BLOCK_WRITE:
                                if (byte_count_reg < BLOCK_WRITE_CNT)
                                    res = make_rsp(KIND_DISACK, '0, '0, REASON_FEWER, '0,
                                                   locked_port_reg, 1'b0);
                                else if (byte_count_reg > BLOCK_WRITE_CNT)
                                    res = make_rsp(KIND_DISACK, '0, '0, REASON_MORE, '0,
                                                   locked_port_reg, 1'b0);
                                else if (!sum_ok)
                                    res = make_rsp(KIND_DISACK, '0, '0, REASON_CHECKSUM,
                                                   '0, locked_port_reg, 1'b0);
                                else
                                    res = make_rsp(KIND_ACK, '0, '0, '0, '0,
                                                   locked_port_reg,
                                                   block_number_reg == LAST_BLOCK);
                            CMD_PING:
                                res = make_rsp(KIND_ACK, '0, '0, '0, '0,
                                               locked_port_reg, 1'b0);
                            default:
                                res_valid = 1'b0;
                        endcase
                    end
                    do_finish = 1'b1;
                end
                else if (!command_seen_reg)
                begin
                    command_seen_next = 1'b1;
                    command_code_next = b;
                    case (b)
                        CMD_PATCH_WRITE, CMD_BLOCK_WRITE:
                        begin
                            running_sum_next  = 8'd0;
                            byte_count_next   = 16'd0;
                            received_sum_next = 8'd0;
                        end
                        CMD_FULL_READ, CMD_BLOCK_READ, CMD_PING:
                        begin
                            command_seen_next = 1'b1;
                        end
                        default:
                        begin
                            res_valid = 1'b1;
                            res = make_rsp(KIND_DISACK, '0, '0, REASON_INVALID, '0,
                                           item.port, 1'b0);
                            do_finish = 1'b1;
                        end
                    endcase
                end
                else
                begin
                    case (command_code_reg)
                        CMD_PATCH_WRITE:
                        begin
                            if (byte_count_reg < PATCH_CNT)
                            begin
                                res_valid = 1'b1;
                                res = make_rsp(KIND_WRITE, byte_count_reg[14:0], b[6:0],
                                               '0, '0, 8'd0, 1'b0);
                                running_sum_next = running_sum_reg + b;
                            end
                            else if (byte_count_reg == PATCH_CNT)
                            begin
                                received_sum_next = b;
                            end
                            byte_count_next = count_inc;
                        end
                        CMD_BLOCK_READ:
                        begin
                            if (!block_seen_reg)
                            begin
                                block_number_next = b;
                                block_seen_next   = 1'b1;
                            end
                        end
                        CMD_BLOCK_WRITE:
                        begin
                            if (!block_seen_reg)
                            begin
                                block_number_next = b;
                                block_seen_next   = 1'b1;
                                running_sum_next  = running_sum_reg + b;
                            end
                            else
                            begin
                                if (byte_count_reg < BLOCK_BYTES)
                                begin
                                    res_valid = 1'b1;
                                    res = make_rsp(KIND_WRITE,
                                                   {block_number_reg[6:0],
                                                    byte_count_reg[7:0]},
                                                   b[6:0], '0, '0, 8'd0, 1'b0);
                                    running_sum_next = running_sum_reg + b;
                                end
                                else if (byte_count_reg == BLOCK_BYTES)
                                begin
                                    received_sum_next = b;
                                end
                                byte_count_next = count_inc;
                            end
                        end
                        default:
                        begin
                            res_valid = 1'b0;
                        end
                    endcase
                end
            end
        end

        if (do_finish)
        begin
            header_count_next = 3'd0;
            in_message_next   = 1'b0;
            command_seen_next = 1'b0;
            block_seen_next   = 1'b0;
            command_code_next = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_count_reg <= 3'd0;
            in_message_reg   <= 1'b0;
            command_seen_reg <= 1'b0;
            block_seen_reg   <= 1'b0;
            command_code_reg <= 8'd0;
            locked_port_reg  <= DEFAULT_PORT;
            running_sum_reg  <= 8'd0;
            received_sum_reg <= 8'd0;
            byte_count_reg   <= 16'd0;
            block_number_reg <= 8'd0;
        end
        else
        begin
            header_count_reg <= header_count_next;
            in_message_reg   <= in_message_next;
            command_seen_reg <= command_seen_next;
            block_seen_reg   <= block_seen_next;
            command_code_reg <= command_code_next;
            locked_port_reg  <= locked_port_next;
            running_sum_reg  <= running_sum_next;
            received_sum_reg <= received_sum_next;
            byte_count_reg   <= byte_count_next;
            block_number_reg <= block_number_next;
        end
    end

endmodule

`default_nettype wire
